// ----- design/ifr_pkg.sv -----
// shared types and constants of the icmp frame rewriter
// no dependencies; used by icmp_frame_rewriter
package ifr_pkg;

	localparam int MaxHeaderWords = 37;
	localparam int AddrW = $clog2(MaxHeaderWords);
	localparam int CntW = 6;
	localparam int SumW = 22;
	localparam int WordW = 16;
	localparam int BvW = 2;
	localparam int IpW = 32;
	localparam int CfgIdxW = 1;
	localparam int StepW = 3;

	localparam logic [CntW-1:0] EthWords = CntW'(7);
	localparam logic [CntW-1:0] ChecksumIdx = CntW'(12);
	localparam logic [CntW-1:0] SrcHiIdx = CntW'(13);
	localparam logic [CntW-1:0] SrcLoIdx = CntW'(14);
	localparam logic [CntW-1:0] DstHiIdx = CntW'(15);
	localparam logic [CntW-1:0] DstLoIdx = CntW'(16);
	localparam logic [CntW-1:0] EthertypeIdx = CntW'(6);
	localparam logic [CntW-1:0] ProtoIdx = CntW'(11);
	localparam logic [CntW-1:0] MacWords = CntW'(3);
	localparam logic [CntW-1:0] MacPairWords = CntW'(6);
	localparam logic [3:0] MinIhl = 4'd5;

	localparam logic [WordW-1:0] EthertypeIpv4 = 16'h0800;
	localparam logic [7:0] ProtoIcmp = 8'h01;
	localparam logic [BvW-1:0] BvOne = 2'd1;
	localparam logic [BvW-1:0] BvTwo = 2'd2;

	localparam logic [CfgIdxW-1:0] CfgSrcIp = 1'd0;
	localparam logic [CfgIdxW-1:0] CfgDstIp = 1'd1;
	localparam logic [IpW-1:0] SrcIpReset = 32'h0102_0304;
	localparam logic [IpW-1:0] DstIpReset = 32'h674D_381B;

	// checksum finishing steps on the shared adder
	localparam logic [StepW-1:0] StepSrcHi = 3'd0;
	localparam logic [StepW-1:0] StepSrcLo = 3'd1;
	localparam logic [StepW-1:0] StepDstHi = 3'd2;
	localparam logic [StepW-1:0] StepDstLo = 3'd3;
	localparam logic [StepW-1:0] StepFold1 = 3'd4;
	localparam logic [StepW-1:0] StepFold2 = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HEAD,
		ST_PASS,
		ST_DROP,
		ST_SUM,
		ST_EMIT_RD,
		ST_EMIT_LD
	} state_t;

endpackage

// ----- design/icmp_frame_rewriter.sv -----
// top level of the icmp frame rewriter: header hold, checksum sequencer, output register
// depends on ifr_pkg and ifr_ram
//
// usage
// - input stream (s_axis_*): one 16-bit big-endian frame word per transaction,
//   tlast on the final word, tdata[17:16] gives the valid bytes of the word
// - output stream (m_axis_*): rewritten frame words; tuser flags the last word
//   produced by one input transaction, tlast marks the final word of the frame
// - cfg port: cfg_we writes cfg_wdata into the ip register selected by cfg_addr
//   (0 new source ip, 1 new destination ip); write only while the block is idle
// - header words are held in a small ram and checked when the header completes; frames not
//   ipv4/icmp, with a bad ihl, ending early or with a one-byte last header word are dropped
// - header words are taken one per cycle; after the completing word the shared
//   adder adds the new address halves and folds the sum twice to finish the checksum,
//   then the header goes out word by word (ram read, then output load); no input
//   is taken while the checksum is finished and a 17 to 37 word header goes out
// - payload words pass through the output register at one per cycle unless the receiver stalls
// - a stalled receiver holds the output register; header emission and the
//   pass-through wait for it, and the input side stalls with them
// - reset clears the sequencer, the output valid and restores the ip registers
module icmp_frame_rewriter (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // [15:0] data_word, [17:16] bytes_valid, [23:18] zero
	input  logic        s_axis_tlast,  // frame_end
	// output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [15:0] out_word, [17:16] out_bytes_valid, [23:18] zero
	output logic        m_axis_tlast,  // out_frame_end
	output logic [0:0]  m_axis_tuser,  // [0] run_end
	// configuration
	input  logic        cfg_we,
	input  logic [ifr_pkg::CfgIdxW-1:0] cfg_addr,
	input  logic [ifr_pkg::IpW-1:0]     cfg_wdata
);

	ifr_pkg::state_t state_q, state_d;

	// config registers
	logic [ifr_pkg::IpW-1:0] src_ip_q;
	logic [ifr_pkg::IpW-1:0] dst_ip_q;

	// header tracking
	logic [ifr_pkg::CntW-1:0]  word_idx_q;
	logic [ifr_pkg::CntW-1:0]  hdr_cnt_q;
	logic [ifr_pkg::SumW-1:0]  sum_q;
	logic [ifr_pkg::WordW-1:0] etype_q;
	logic [7:0]                proto_q;
	logic                      fe_q;
	logic [ifr_pkg::StepW-1:0] step_q;
	logic [ifr_pkg::CntW-1:0]  emit_k_q;

	// output register
	logic                      out_valid_q;
	logic [ifr_pkg::WordW-1:0] out_word_q;
	logic [ifr_pkg::BvW-1:0]   out_bv_q;
	logic                      out_fe_q;
	logic                      out_re_q;

	// input fields
	logic [ifr_pkg::WordW-1:0] in_word;
	logic [ifr_pkg::BvW-1:0]   in_bv;
	logic                      in_fe;
	logic                      acc;
	logic                      out_free;

	// header word decode
	logic [ifr_pkg::CntW-1:0] idx_cur;
	logic [ifr_pkg::CntW-1:0] idx_next;
	logic [3:0]               ihl;
	logic [ifr_pkg::CntW-1:0] cnt_new;
	logic [ifr_pkg::CntW-1:0] cnt_eff;
	logic                     bad_ihl;
	logic                     complete;
	logic                     reject;
	logic                     sum_count;
	logic                     last_emit;

	// sequencer outputs
	logic in_ready;
	logic head_acc;
	logic pass_acc;
	logic emit_load;
	logic sum_step;

	// shared adder
	logic [ifr_pkg::SumW-1:0] add_a;
	logic [ifr_pkg::SumW-1:0] add_b;
	logic [ifr_pkg::SumW-1:0] add_res;

	// header ram
	logic                      ram_we;
	logic [ifr_pkg::AddrW-1:0] ram_waddr;
	logic [ifr_pkg::CntW-1:0]  rd_map;
	logic [ifr_pkg::WordW-1:0] ram_rdata;
	logic [ifr_pkg::WordW-1:0] emit_word;
	logic [ifr_pkg::WordW-1:0] checksum;

	assign in_word  = s_axis_tdata[15:0];
	assign in_bv    = s_axis_tdata[17:16];
	assign in_fe    = s_axis_tlast;
	assign acc      = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;

	// a new frame starts its index and sum from zero
	assign idx_cur  = (state_q == ifr_pkg::ST_IDLE) ? '0 : word_idx_q;
	assign idx_next = idx_cur + ifr_pkg::CntW'(1);
	assign ihl      = in_word[11:8];
	assign cnt_new  = ifr_pkg::EthWords + {1'b0, ihl, 1'b0};
	assign cnt_eff  = (idx_cur == ifr_pkg::EthWords) ? cnt_new : hdr_cnt_q;
	assign bad_ihl  = (idx_cur == ifr_pkg::EthWords) &&
		((ihl < ifr_pkg::MinIhl) || (cnt_new > ifr_pkg::CntW'(ifr_pkg::MaxHeaderWords)));
	assign complete = !bad_ihl && (idx_cur >= ifr_pkg::EthWords) && (idx_next == cnt_eff);
	assign reject   = (in_bv == ifr_pkg::BvOne) || (etype_q != ifr_pkg::EthertypeIpv4) ||
		(proto_q != ifr_pkg::ProtoIcmp);
	// the checksum field and the address words stay out of the running sum
	assign sum_count = (idx_cur >= ifr_pkg::EthWords) && (idx_cur != ifr_pkg::ChecksumIdx) &&
		!((idx_cur >= ifr_pkg::SrcHiIdx) && (idx_cur <= ifr_pkg::DstLoIdx));
	assign last_emit = (emit_k_q == hdr_cnt_q - ifr_pkg::CntW'(1));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ifr_pkg::ST_IDLE, ifr_pkg::ST_HEAD: begin
				if (acc) begin
					if (bad_ihl || (complete && reject)) begin
						state_d = in_fe ? ifr_pkg::ST_IDLE : ifr_pkg::ST_DROP;
					end else if (complete) begin
						state_d = ifr_pkg::ST_SUM;
					end else if (in_fe) begin
						state_d = ifr_pkg::ST_IDLE;
					end else begin
						state_d = ifr_pkg::ST_HEAD;
					end
				end
			end
			ifr_pkg::ST_PASS: begin
				if (acc && in_fe) begin
					state_d = ifr_pkg::ST_IDLE;
				end
			end
			ifr_pkg::ST_DROP: begin
				if (acc && in_fe) begin
					state_d = ifr_pkg::ST_IDLE;
				end
			end
			ifr_pkg::ST_SUM: begin
				if (step_q == ifr_pkg::StepFold2) begin
					state_d = ifr_pkg::ST_EMIT_RD;
				end
			end
			ifr_pkg::ST_EMIT_RD: begin
				state_d = ifr_pkg::ST_EMIT_LD;
			end
			ifr_pkg::ST_EMIT_LD: begin
				if (out_free) begin
					if (last_emit) begin
						state_d = fe_q ? ifr_pkg::ST_IDLE : ifr_pkg::ST_PASS;
					end else begin
						state_d = ifr_pkg::ST_EMIT_RD;
					end
				end
			end
			default: begin
				state_d = ifr_pkg::ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready  = 1'b0;
		head_acc  = 1'b0;
		pass_acc  = 1'b0;
		emit_load = 1'b0;
		sum_step  = 1'b0;
		case (state_q)
			ifr_pkg::ST_IDLE, ifr_pkg::ST_HEAD: begin
				in_ready = 1'b1;
				head_acc = s_axis_tvalid;
			end
			ifr_pkg::ST_PASS: begin
				in_ready = out_free;
				pass_acc = s_axis_tvalid && out_free;
			end
			ifr_pkg::ST_DROP: begin
				in_ready = 1'b1;
			end
			ifr_pkg::ST_SUM: begin
				sum_step = 1'b1;
			end
			ifr_pkg::ST_EMIT_RD: begin
				in_ready = 1'b0;
			end
			ifr_pkg::ST_EMIT_LD: begin
				emit_load = out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign s_axis_tready = in_ready;

	// shared adder: running header sum, then address halves, then two folds
	always_comb begin
		add_a = sum_q;
		add_b = ifr_pkg::SumW'(in_word);
		if (sum_step) begin
			case (step_q)
				ifr_pkg::StepSrcHi: add_b = ifr_pkg::SumW'(src_ip_q[31:16]);
				ifr_pkg::StepSrcLo: add_b = ifr_pkg::SumW'(src_ip_q[15:0]);
				ifr_pkg::StepDstHi: add_b = ifr_pkg::SumW'(dst_ip_q[31:16]);
				ifr_pkg::StepDstLo: add_b = ifr_pkg::SumW'(dst_ip_q[15:0]);
				ifr_pkg::StepFold1: begin
					add_a = ifr_pkg::SumW'(sum_q[ifr_pkg::SumW-1:16]);
					add_b = ifr_pkg::SumW'(sum_q[15:0]);
				end
				ifr_pkg::StepFold2: add_b = ifr_pkg::SumW'(sum_q[ifr_pkg::SumW-1:16]);
				default: add_b = '0;
			endcase
		end else if (state_q == ifr_pkg::ST_IDLE) begin
			add_a = '0;
		end
	end

	assign add_res  = add_a + add_b;
	assign checksum = ~sum_q[15:0];

	// emission order: source mac from words 3..5, destination mac from 0..2
	always_comb begin
		if (emit_k_q < ifr_pkg::MacWords) begin
			rd_map = emit_k_q + ifr_pkg::MacWords;
		end else if (emit_k_q < ifr_pkg::MacPairWords) begin
			rd_map = emit_k_q - ifr_pkg::MacWords;
		end else begin
			rd_map = emit_k_q;
		end
	end

	always_comb begin
		case (emit_k_q)
			ifr_pkg::ChecksumIdx: emit_word = checksum;
			ifr_pkg::SrcHiIdx:    emit_word = src_ip_q[31:16];
			ifr_pkg::SrcLoIdx:    emit_word = src_ip_q[15:0];
			ifr_pkg::DstHiIdx:    emit_word = dst_ip_q[31:16];
			ifr_pkg::DstLoIdx:    emit_word = dst_ip_q[15:0];
			default:              emit_word = ram_rdata;
		endcase
	end

	assign ram_we    = head_acc && (idx_cur < ifr_pkg::CntW'(ifr_pkg::MaxHeaderWords));
	assign ram_waddr = idx_cur[ifr_pkg::AddrW-1:0];

	ifr_ram #(
		.Width (ifr_pkg::WordW),
		.Depth (ifr_pkg::MaxHeaderWords)
	) u_hdr_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (in_word),
		.raddr (rd_map[ifr_pkg::AddrW-1:0]),
		.rdata (ram_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ifr_pkg::ST_IDLE;
			src_ip_q    <= ifr_pkg::SrcIpReset;
			dst_ip_q    <= ifr_pkg::DstIpReset;
			word_idx_q  <= '0;
			hdr_cnt_q   <= '0;
			step_q      <= '0;
			emit_k_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_addr)
					ifr_pkg::CfgSrcIp: src_ip_q <= cfg_wdata;
					ifr_pkg::CfgDstIp: dst_ip_q <= cfg_wdata;
					default: src_ip_q <= src_ip_q;
				endcase
			end
			if (head_acc) begin
				word_idx_q <= idx_next;
				if (idx_cur == ifr_pkg::EthWords) begin
					hdr_cnt_q <= cnt_new;
				end
			end
			// step and emit counters restart whenever a header completes
			if (head_acc && complete) begin
				step_q   <= '0;
				emit_k_q <= '0;
			end else if (sum_step) begin
				step_q <= step_q + ifr_pkg::StepW'(1);
			end else if (emit_load) begin
				emit_k_q <= emit_k_q + ifr_pkg::CntW'(1);
			end
			if (pass_acc || emit_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (head_acc) begin
			if (sum_count) begin
				sum_q <= add_res;
			end else if (state_q == ifr_pkg::ST_IDLE) begin
				sum_q <= '0;
			end
			if (idx_cur == ifr_pkg::EthertypeIdx) begin
				etype_q <= in_word;
			end
			if (idx_cur == ifr_pkg::ProtoIdx) begin
				proto_q <= in_word[7:0];
			end
			fe_q <= in_fe;
		end else if (sum_step) begin
			sum_q <= add_res;
		end
		if (pass_acc) begin
			out_word_q <= in_word;
			out_bv_q   <= (in_bv == ifr_pkg::BvOne) ? ifr_pkg::BvOne : ifr_pkg::BvTwo;
			out_fe_q   <= in_fe;
			out_re_q   <= 1'b1;
		end else if (emit_load) begin
			out_word_q <= emit_word;
			out_bv_q   <= ifr_pkg::BvTwo;
			out_fe_q   <= last_emit && fe_q;
			out_re_q   <= last_emit;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = {6'd0, out_bv_q, out_word_q};
	assign m_axis_tlast    = out_fe_q;
	assign m_axis_tuser[0] = out_re_q;

	// checks
	a_no_input_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ifr_pkg::ST_SUM || state_q == ifr_pkg::ST_EMIT_RD ||
		 state_q == ifr_pkg::ST_EMIT_LD) |-> !s_axis_tready)
		else $error("input taken during checksum or header emission");

	a_hdr_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ifr_pkg::ST_SUM) |->
		(hdr_cnt_q >= ifr_pkg::CntW'(17) &&
		 hdr_cnt_q <= ifr_pkg::CntW'(ifr_pkg::MaxHeaderWords)))
		else $error("header length out of range at checksum");

	a_emit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ifr_pkg::ST_EMIT_LD) |-> (emit_k_q < hdr_cnt_q))
		else $error("header emission past header length");

	a_ram_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (idx_cur < ifr_pkg::CntW'(ifr_pkg::MaxHeaderWords)))
		else $error("header store write out of range");

	a_load_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(pass_acc || emit_load) |-> out_free)
		else $error("output register overwritten while stalled");

endmodule

// ----- design/ifr_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
module ifr_ram #(
	parameter int Width = 16,
	parameter int Depth = 37
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];
	logic [Width-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- test/tb_icmp_frame_rewriter.sv -----
`timescale 1ns / 1ps
// self-checking testbench for icmp_frame_rewriter: directed and random frames are
// checked beat by beat against an in-bench model of the header rewrite; needs ifr_pkg
module tb_icmp_frame_rewriter;
	import ifr_pkg::*;

	// header burst worst case: checksum finish plus the emission of the longest header, with margin
	localparam int SettleCycles = 6 + 2 * MaxHeaderWords + 16;
	localparam int CycleLimit = 2000000;
	// random traffic goes on until this many input words have been sent in total
	localparam int RandomItems = 440;
	localparam int MaxErrPrints = 40;

	// byte counts outside the nominal range, only used by the odd code test
	localparam logic [BvW-1:0] BvNone = 2'd0;
	localparam logic [BvW-1:0] BvWide = 2'd3;

	typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

	// one output transaction as the block should produce it
	typedef struct packed {
		logic [WordW-1:0] word;
		logic [BvW-1:0]   bv;
		logic             fe;
		logic             re;
	} out_beat_t;

	// one input transaction
	typedef struct packed {
		logic [WordW-1:0] word;
		logic             fe;
		logic [BvW-1:0]   bv;
	} in_word_t;

	logic clk = 1'b0;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [23:0] s_axis_tdata;   // [15:0] data_word, [17:16] bytes_valid, [23:18] zero
	logic s_axis_tlast;          // frame_end
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [23:0] m_axis_tdata;   // [15:0] out_word, [17:16] out_bytes_valid, [23:18] zero
	logic m_axis_tlast;          // out_frame_end
	logic [0:0] m_axis_tuser;    // [0] run_end
	logic cfg_we;
	logic [CfgIdxW-1:0] cfg_addr;
	logic [IpW-1:0] cfg_wdata;

	icmp_frame_rewriter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	// model state of the rewriter
	logic [WordW-1:0] hdr_mem [MaxHeaderWords];
	logic [CntW-1:0]  hdr_pos;
	logic [CntW-1:0]  hdr_len;
	logic [SumW-1:0]  hdr_sum;
	state_t           rw_phase;
	logic [IpW-1:0]   src_ip;
	logic [IpW-1:0]   dst_ip;

	// rewritten words still owed by the block, oldest first
	out_beat_t rewritten_q[$];
	// words of the frame being sent
	in_word_t frame_q[$];
	out_beat_t exp_beat;
	out_beat_t got_beat;

	int err_cnt = 0;
	int cycle_cnt = 0;
	int sent_cnt = 0;
	bit tx_idle_en = 1'b1;
	bit rx_idle_en = 1'b1;
	int rx_hold_req = 0;

	// free-running clock, 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// hang guard
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CycleLimit) begin
			$display("status: fail");
			$finish;
		end
	end

	// emit the held header: mac swap, new addresses and a fresh checksum
	task automatic emit_rewritten_header(input logic fe);
		logic [31:0] s;
		logic [WordW-1:0] ck;
		logic [WordW-1:0] w;
		int n;
		int k;
		n = int'(hdr_len);
		// the address words were left out of the running sum, add the new ones
		s = 32'(hdr_sum) + src_ip[31:16] + src_ip[15:0] + dst_ip[31:16] + dst_ip[15:0];
		s = (s >> 16) + (s & 32'hffff);
		s = s + (s >> 16);
		ck = ~s[15:0];
		for (k = 0; k < n; k++) begin
			if (k < MacWords) w = hdr_mem[k + MacWords];
			else if (k < MacPairWords) w = hdr_mem[k - MacWords];
			else if (k == ChecksumIdx) w = ck;
			else if (k == SrcHiIdx) w = src_ip[31:16];
			else if (k == SrcLoIdx) w = src_ip[15:0];
			else if (k == DstHiIdx) w = dst_ip[31:16];
			else if (k == DstLoIdx) w = dst_ip[15:0];
			else w = hdr_mem[k];
			rewritten_q.push_back('{word: w, bv: BvTwo, fe: (k == n - 1) ? fe : 1'b0,
				re: (k == n - 1)});
		end
	endtask

	// advance the model by one accepted input word
	task automatic predict_rewrite(input in_word_t iw);
		logic [CntW-1:0] pos;
		logic [3:0] ihl;
		logic drop;
		drop = 1'b0;
		if (rw_phase == ST_DROP) begin
			if (iw.fe) rw_phase = ST_IDLE;
			return;
		end
		if (rw_phase == ST_PASS) begin
			rewritten_q.push_back('{word: iw.word, bv: (iw.bv == BvOne) ? BvOne : BvTwo,
				fe: iw.fe, re: 1'b1});
			if (iw.fe) rw_phase = ST_IDLE;
			return;
		end
		if (rw_phase == ST_IDLE) begin
			hdr_pos = '0;
			hdr_len = '0;
			hdr_sum = '0;
			rw_phase = ST_HEAD;
		end
		pos = hdr_pos;
		if (pos < MaxHeaderWords) hdr_mem[pos] = iw.word;
		// first ip word carries ihl, which fixes the header length
		if (pos == EthWords) begin
			ihl = iw.word[11:8];
			hdr_len = CntW'(int'(EthWords) + 2 * int'(ihl));
			if (ihl < MinIhl || hdr_len > MaxHeaderWords) drop = 1'b1;
		end
		// running sum skips the checksum and the four address words
		if (pos >= EthWords && pos != ChecksumIdx && (pos < SrcHiIdx || pos > DstLoIdx))
			hdr_sum = hdr_sum + SumW'(iw.word);
		hdr_pos = pos + 1'b1;
		if (!drop && pos >= EthWords && hdr_pos == hdr_len) begin
			if (iw.bv == BvOne || hdr_mem[EthertypeIdx] != EthertypeIpv4 ||
					hdr_mem[ProtoIdx][7:0] != ProtoIcmp) begin
				drop = 1'b1;
			end else begin
				emit_rewritten_header(iw.fe);
				rw_phase = iw.fe ? ST_IDLE : ST_PASS;
				return;
			end
		end
		if (drop) begin
			rw_phase = iw.fe ? ST_IDLE : ST_DROP;
			return;
		end
		if (iw.fe) rw_phase = ST_IDLE;
	endtask

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		int hold_left;
		int stall_left;
		hold_left = 0;
		stall_left = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_req > 0) begin
				hold_left = rx_hold_req;
				rx_hold_req = 0;
			end
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 1'b0;
				stall_left = $urandom_range(1, 15) - 1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// output checker: every output transaction against the oldest owed word
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_beat = '{word: m_axis_tdata[15:0], bv: m_axis_tdata[17:16],
				fe: m_axis_tlast, re: m_axis_tuser[0]};
			if (rewritten_q.size() == 0) begin
				err_cnt++;
				if (err_cnt <= MaxErrPrints)
					$display("%0t: unexpected transaction, expected none, actual word %h bv %0d last %0b run_end %0b",
						$time, got_beat.word, got_beat.bv, got_beat.fe, got_beat.re);
			end else begin
				exp_beat = rewritten_q.pop_front();
				if (got_beat !== exp_beat) begin
					err_cnt++;
					if (err_cnt <= MaxErrPrints)
						$display("%0t: mismatch, expected word %h bv %0d last %0b run_end %0b, actual word %h bv %0d last %0b run_end %0b",
							$time, exp_beat.word, exp_beat.bv, exp_beat.fe, exp_beat.re,
							got_beat.word, got_beat.bv, got_beat.fe, got_beat.re);
				end
			end
		end
	end

	// one input transaction; valid stays up unless a gap follows
	task automatic send_word(input in_word_t iw);
		s_axis_tdata <= {6'd0, iw.bv, iw.word};
		s_axis_tlast <= iw.fe;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_rewrite(iw);
		sent_cnt++;
		if (tx_idle_en && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	task automatic send_frame();
		foreach (frame_q[i]) send_word(frame_q[i]);
	endtask

	// stop offering and wait until every owed word has come out
	task automatic wait_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (rewritten_q.size() != 0) @(posedge clk);
	endtask

	// block idle: nothing owed and any header burst or drop finished
	task automatic wait_idle();
		wait_results();
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_addresses(input logic [IpW-1:0] src, input logic [IpW-1:0] dst);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_addr <= CfgSrcIp;
		cfg_wdata <= src;
		@(posedge clk);
		cfg_addr <= CfgDstIp;
		cfg_wdata <= dst;
		@(posedge clk);
		cfg_we <= 1'b0;
		src_ip = src;
		dst_ip = dst;
	endtask

	function automatic logic [WordW-1:0] fill_word(input fill_t fill);
		case (fill)
			FILL_ZERO: return '0;
			FILL_ONES: return '1;
			default: return WordW'($urandom);
		endcase
	endfunction

	// ethernet + ipv4 header with the given key fields, then payload words
	task automatic build_frame(input int ihl, input logic [WordW-1:0] ethertype,
			input logic [7:0] proto, input int payload, input logic odd_tail,
			input fill_t fill);
		int hlen;
		int total;
		int i;
		logic [WordW-1:0] v;
		frame_q.delete();
		// a short ihl still gets a minimal header's worth of words
		hlen = (ihl >= MinIhl) ? int'(EthWords) + 2 * ihl
			: int'(EthWords) + 2 * int'(MinIhl);
		total = hlen + payload;
		for (i = 0; i < total; i++) begin
			v = fill_word(fill);
			if (i == EthertypeIdx) v = ethertype;
			else if (i == EthWords) v[11:8] = 4'(ihl);
			else if (i == ProtoIdx) v[7:0] = proto;
			frame_q.push_back('{word: v, fe: (i == total - 1), bv: BvTwo});
		end
		if (odd_tail) frame_q[total - 1].bv = BvOne;
	endtask

	// end the frame early after n words
	task automatic cut_frame(input int n);
		while (frame_q.size() > n) void'(frame_q.pop_back());
		frame_q[n - 1].fe = 1'b1;
		frame_q[n - 1].bv = $urandom_range(0, 1) ? BvOne : BvTwo;
	endtask

	task automatic good_frame(input int payload);
		build_frame(MinIhl, EthertypeIpv4, ProtoIcmp, payload, 1'($urandom_range(0, 1)),
			FILL_RANDOM);
		send_frame();
	endtask

	// mostly well-formed icmp frames, the rest broken or noise
	task automatic random_frame();
		int kind;
		int ihl;
		int n;
		int i;
		logic [WordW-1:0] et;
		logic [7:0] pr;
		fill_t fill;
		kind = $urandom_range(0, 99);
		ihl = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 15) : int'(MinIhl);
		et = EthertypeIpv4;
		pr = ProtoIcmp;
		fill = ($urandom_range(0, 15) == 0) ? fill_t'($urandom_range(1, 2)) : FILL_RANDOM;
		if (kind < 6) et = et ^ WordW'($urandom_range(1, 16'hffff));
		else if (kind < 12) pr = pr ^ 8'($urandom_range(1, 255));
		else if (kind < 18) ihl = $urandom_range(0, 4);
		build_frame(ihl, et, pr, $urandom_range(0, 10), 1'($urandom_range(0, 1)), fill);
		if (kind >= 18 && kind < 26) begin
			// end somewhere inside the header
			cut_frame($urandom_range(1, int'(EthWords) + 2 * ihl - 1));
		end else if (kind >= 26 && kind < 30) begin
			// plain noise, almost never a valid ethertype
			frame_q.delete();
			n = $urandom_range(1, 24);
			for (i = 0; i < n; i++)
				frame_q.push_back('{word: WordW'($urandom), fe: (i == n - 1), bv: BvTwo});
		end
		send_frame();
	endtask

	// ---- tests ----

	// rewrite with the addresses left from reset
	task automatic test_reset_addresses();
		build_frame(MinIhl, EthertypeIpv4, ProtoIcmp, 3, 1'b1, FILL_RANDOM);
		send_frame();
	endtask

	// all-zero and all-one header content, and the longest header
	task automatic test_field_extremes();
		build_frame(MinIhl, EthertypeIpv4, ProtoIcmp, 2, 1'b0, FILL_ZERO);
		send_frame();
		build_frame(MinIhl, EthertypeIpv4, ProtoIcmp, 2, 1'b1, FILL_ONES);
		send_frame();
		build_frame(15, EthertypeIpv4, ProtoIcmp, 1, 1'b0, FILL_RANDOM);
		send_frame();
	endtask

	// frame ends on the word that completes the header
	task automatic test_header_only_frame();
		build_frame(MinIhl, EthertypeIpv4, ProtoIcmp, 0, 1'b0, FILL_RANDOM);
		send_frame();
		// odd completing word drops the frame
		build_frame(6, EthertypeIpv4, ProtoIcmp, 0, 1'b1, FILL_RANDOM);
		send_frame();
	endtask

	// ihl below the minimum drops at the first ip word
	task automatic test_short_ihl();
		build_frame(4, EthertypeIpv4, ProtoIcmp, 2, 1'b0, FILL_RANDOM);
		send_frame();
		build_frame(0, EthertypeIpv4, ProtoIcmp, 0, 1'b1, FILL_RANDOM);
		send_frame();
	endtask

	// not ipv4, or ipv4 but not icmp
	task automatic test_wrong_type();
		build_frame(MinIhl, 16'h86dd, ProtoIcmp, 2, 1'b0, FILL_RANDOM);
		send_frame();
		build_frame(MinIhl, EthertypeIpv4, 8'h06, 2, 1'b1, FILL_RANDOM);
		send_frame();
	endtask

	// frames that end before the header is complete
	task automatic test_truncated();
		build_frame(MinIhl, EthertypeIpv4, ProtoIcmp, 0, 1'b0, FILL_RANDOM);
		cut_frame(1);
		send_frame();
		build_frame(MinIhl, EthertypeIpv4, ProtoIcmp, 0, 1'b0, FILL_RANDOM);
		cut_frame(EthWords);
		send_frame();
		build_frame(MinIhl, EthertypeIpv4, ProtoIcmp, 0, 1'b0, FILL_RANDOM);
		cut_frame(EthWords + 1);
		send_frame();
		build_frame(MinIhl, EthertypeIpv4, ProtoIcmp, 0, 1'b0, FILL_RANDOM);
		cut_frame(2 * MinIhl + EthWords - 1);
		send_frame();
		good_frame(2);
	endtask

	// completing word with a single valid byte, payload follows and is dropped
	task automatic test_completing_odd();
		build_frame(MinIhl, EthertypeIpv4, ProtoIcmp, 3, 1'b0, FILL_RANDOM);
		frame_q[2 * MinIhl + EthWords - 1].bv = BvOne;
		send_frame();
	endtask

	// byte counts 0 and 3 in the header and in the pass-through
	task automatic test_odd_codes();
		build_frame(MinIhl, EthertypeIpv4, ProtoIcmp, 4, 1'b1, FILL_RANDOM);
		frame_q[3].bv = BvNone;
		frame_q[9].bv = BvWide;
		frame_q[2 * MinIhl + EthWords - 1].bv = BvWide;
		frame_q[2 * MinIhl + EthWords].bv = BvNone;
		frame_q[2 * MinIhl + EthWords + 1].bv = BvWide;
		send_frame();
	endtask

	// several address settings, extremes included
	task automatic test_config_sweep();
		write_addresses('0, '0);
		good_frame(1);
		write_addresses('1, '1);
		good_frame(1);
		write_addresses('1, '0);
		good_frame(0);
		write_addresses($urandom, $urandom);
		good_frame(2);
	endtask

	// long receiver hold-off while the sender keeps pushing
	task automatic test_backpressure();
		tx_idle_en = 1'b0;
		rx_hold_req = 400;
		repeat (2) good_frame(4);
		wait_results();
		tx_idle_en = 1'b1;
	endtask

	// sender waits for all results between frames
	task automatic test_drain_pause();
		repeat (2) begin
			good_frame($urandom_range(0, 3));
			wait_results();
		end
	endtask

	// random traffic until the input budget is used
	task automatic test_random_traffic();
		do begin
			random_frame();
		end while (sent_cnt < RandomItems);
	endtask

	// closing stretch at full rate on both sides
	task automatic test_full_rate();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		repeat (2) random_frame();
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = CfgSrcIp;
		cfg_wdata = '0;
		rw_phase = ST_IDLE;
		hdr_pos = '0;
		hdr_len = '0;
		hdr_sum = '0;
		src_ip = SrcIpReset;
		dst_ip = DstIpReset;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_addresses();
		test_field_extremes();
		test_header_only_frame();
		test_short_ihl();
		test_wrong_type();
		test_truncated();
		test_completing_odd();
		test_odd_codes();
		test_config_sweep();
		test_backpressure();
		test_drain_pause();
		test_random_traffic();
		test_full_rate();

		// drain, then watch for stray output
		wait_idle();
		if (err_cnt == 0 && rewritten_q.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
design/ifr_pkg.sv
design/ifr_ram.sv
design/icmp_frame_rewriter.sv
test/tb_icmp_frame_rewriter.sv
